### rtl/assert_macros.svh
// Assertion helpers included by the hash table RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to nothing
// in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

    localparam int KEY_W    = 31;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_FW  = 4;
    localparam int COUNT_FW = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // One table entry as stored in the slot memory.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_word_t;

endpackage

`default_nettype wire

### rtl/linear_probing_hash_table.sv
`default_nettype none

// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tuser = mode, s_tdata = key
// m_       out  m_tvalid/m_tready  m_tuser = status, m_tdata = slot, entry_count
//
// One item at a time: accept, home slot, then probing through the slot memory
// (one write port, one registered read port), one read per slot, and then the
// output register is loaded.
// After reset every slot of the memory is swept clear before s_tready rises.
// A stalled result waits in the output register; a further result waits in the
// finishing stage until m_tready frees the register.
module linear_probing_hash_table #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] key, [31] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [3:0] slot, [8:4] entry_count, [15:9] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HASH  = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [SLOT_W-1:0]                addr_reg, addr_next;
    logic [CNT_W-1:0]                 iss_cnt_reg, iss_cnt_next;
    logic                             pend_reg, pend_next;
    logic                             pend_last_reg, pend_last_next;
    logic [SLOT_W-1:0]                pend_addr_reg, pend_addr_next;
    logic [lpht_pkg::MODE_W-1:0]      mode_reg;
    logic [lpht_pkg::KEY_W-1:0]       key_reg;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [lpht_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [SLOT_W-1:0]                res_slot_reg, res_slot_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [lpht_pkg::STATUS_W-1:0]    m_status_reg;
    logic [lpht_pkg::SLOT_FW-1:0]     m_slot_reg;
    logic [lpht_pkg::COUNT_FW-1:0]    m_count_reg;

    lpht_pkg::slot_word_t             mem [TABLE_SLOTS];
    lpht_pkg::slot_word_t             rd_word_reg;
    lpht_pkg::slot_word_t             mem_wd;
    logic                             mem_we;
    logic [SLOT_W-1:0]                mem_wa;

    logic                             accept;
    logic                             load_out;
    logic                             key_hit;
    logic                             stop;
    logic                             home_done;
    logic [SLOT_W-1:0]                home;
    logic [SLOT_W-1:0]                addr_inc;
    logic [31:0]                      slot_ext;
    logic [31:0]                      count_ext;

    lpht_home #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_home (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (accept),
        .key    (s_tdata[lpht_pkg::KEY_W-1:0]),
        .done   (home_done),
        .home   (home)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign key_hit  = rd_word_reg.valid && (rd_word_reg.key == key_reg);
    assign addr_inc = (addr_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : addr_reg + SLOT_W'(1);

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        iss_cnt_next    = iss_cnt_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        pend_addr_next  = pend_addr_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        mem_we          = 1'b0;
        mem_wa          = pend_addr_reg;
        mem_wd          = '0;
        stop            = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wa    = addr_reg;
                addr_next = addr_inc;
                if (addr_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (home_done) begin
                    addr_next       = (mode_reg == lpht_pkg::MODE_DELETE) ? '0 : home;
                    iss_cnt_next    = '0;
                    pend_next       = 1'b0;
                    res_slot_next   = '0;
                    res_status_next = (mode_reg == lpht_pkg::MODE_INSERT)
                                      ? lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_MISS;
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // Reads are issued every cycle; the data of the previous read is
                // checked while the next one is in flight.
                pend_next      = (iss_cnt_reg != CNT_W'(TABLE_SLOTS));
                pend_last_next = (iss_cnt_reg == CNT_W'(TABLE_SLOTS - 1));
                pend_addr_next = addr_reg;
                if (pend_next) begin
                    addr_next    = addr_inc;
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    case (mode_reg)
                        lpht_pkg::MODE_INSERT: begin
                            if (!rd_word_reg.valid) begin
                                mem_we          = 1'b1;
                                mem_wd.valid    = 1'b1;
                                mem_wd.key      = key_reg;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = lpht_pkg::STATUS_DONE;
                                res_slot_next   = pend_addr_reg;
                                stop            = 1'b1;
                            end
                        end
                        lpht_pkg::MODE_DELETE: begin
                            if (key_hit) begin
                                mem_we = 1'b1;
                                if (count_reg != '0) begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                                if (res_status_reg != lpht_pkg::STATUS_DONE) begin
                                    res_status_next = lpht_pkg::STATUS_DONE;
                                    res_slot_next   = pend_addr_reg;
                                end
                            end
                        end
                        lpht_pkg::MODE_SEARCH: begin
                            if (key_hit) begin
                                res_status_next = lpht_pkg::STATUS_DONE;
                                res_slot_next   = pend_addr_reg;
                                stop            = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (pend_last_reg) begin
                        stop = 1'b1;
                    end
                end
                if (stop) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign slot_ext  = 32'(res_slot_reg);
    assign count_ext = 32'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        iss_cnt_reg    <= iss_cnt_next;
        pend_last_reg  <= pend_last_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (accept) begin
            mode_reg <= s_tuser;
            key_reg  <= s_tdata[lpht_pkg::KEY_W-1:0];
        end
        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= slot_ext[lpht_pkg::SLOT_FW-1:0];
            m_count_reg  <= count_ext[lpht_pkg::COUNT_FW-1:0];
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_word_reg <= mem[addr_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_count_reg, m_slot_reg};

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(TABLE_SLOTS), "entry count exceeds table size")
    `ASSERT_IMPLIES(a_probe_bound, aclk, aresetn, state_reg == ST_PROBE, iss_cnt_reg <= CNT_W'(TABLE_SLOTS), "probe ran past the table")
    `ASSERT_IMPLIES(a_write_pending, aclk, aresetn, mem_we && (state_reg == ST_PROBE), pend_reg, "probe write without read data")
    `ASSERT_IMPLIES(a_full_status, aclk, aresetn, load_out && (res_status_reg == lpht_pkg::STATUS_FULL), count_reg == CNT_W'(TABLE_SLOTS), "full status with free slots")
    `ASSERT_NEXT(a_insert_count, aclk, aresetn, (state_reg == ST_PROBE) && mem_we && (mode_reg == lpht_pkg::MODE_INSERT), count_reg == $past(count_reg) + CNT_W'(1), "insert did not count the item")

endmodule

`default_nettype wire

### rtl/lpht_home.sv
`default_nettype none

// Computes the home slot, key mod TABLE_SLOTS. A power-of-two table registers the
// low key bits; any other size first registers the quotient of a multiplication by a
// scaled reciprocal and then registers a small correction on the low key bits.
module lpht_home #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [lpht_pkg::KEY_W-1:0]       key,
    output logic                                  done,
    output logic [$clog2(TABLE_SLOTS)-1:0]        home
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    generate
        if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
            logic              done_reg;
            logic [SLOT_W-1:0] home_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    home_reg <= key[SLOT_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end else begin : g_recip
            // The quotient is the top of key * RECIP. Since the remainder is below
            // the table size, only the low bits of the quotient are needed to form it.
            localparam int SHIFT  = lpht_pkg::KEY_W + SLOT_W;
            localparam int PROD_W = lpht_pkg::KEY_W + 32;
            localparam logic [31:0] RECIP =
                32'(((longint'(1) << SHIFT) + longint'(TABLE_SLOTS) - longint'(1))
                    / longint'(TABLE_SLOTS));

            logic                quot_vld_reg;
            logic                done_reg;
            logic [SLOT_W-1:0]   quot_reg;
            logic [SLOT_W-1:0]   key_lo_reg;
            logic [SLOT_W-1:0]   home_reg;
            logic [PROD_W-1:0]   prod;
            logic [2*SLOT_W-1:0] quot_mul;

            assign prod     = PROD_W'(key) * PROD_W'(RECIP);
            assign quot_mul = (2*SLOT_W)'(quot_reg) * (2*SLOT_W)'(TABLE_SLOTS);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    quot_vld_reg <= 1'b0;
                    done_reg     <= 1'b0;
                end else begin
                    quot_vld_reg <= start;
                    done_reg     <= quot_vld_reg;
                end
                if (start) begin
                    quot_reg   <= prod[SHIFT +: SLOT_W];
                    key_lo_reg <= key[SLOT_W-1:0];
                end
                if (quot_vld_reg) begin
                    home_reg <= key_lo_reg - quot_mul[SLOT_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
    endgenerate

endmodule

`default_nettype wire
